### hdl/tgadec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA stream decoder package
// Item types, parse phases, header offsets and format codes for the decoder.
// ----------------------------------------------------------------------------
package tgadec_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] first_row;
		logic [15:0] first_column;
		logic [7:0]  run_count;
		logic        image_done;
		logic [15:0] image_width;
		logic [15:0] image_height;
	} out_item_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_IDSKIP = 3'd1,
		PH_PACKET = 3'd2,
		PH_PIXEL  = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	localparam logic [1:0] KindHeader    = 2'd0;
	localparam logic [1:0] KindRun       = 2'd1;
	localparam logic [1:0] KindBadType   = 2'd2;
	localparam logic [1:0] KindBadFormat = 2'd3;

	localparam logic [4:0] HdrIdLen     = 5'd0;
	localparam logic [4:0] HdrCmapType  = 5'd1;
	localparam logic [4:0] HdrImageType = 5'd2;
	localparam logic [4:0] HdrWidthLo   = 5'd12;
	localparam logic [4:0] HdrWidthHi   = 5'd13;
	localparam logic [4:0] HdrHeightLo  = 5'd14;
	localparam logic [4:0] HdrHeightHi  = 5'd15;
	localparam logic [4:0] HdrDepth     = 5'd16;
	localparam logic [4:0] HdrLast      = 5'd17;

	localparam logic [7:0] TypeTrueColour = 8'd2;
	localparam logic [7:0] TypeGrey       = 8'd3;
	localparam logic [7:0] TypeRle        = 8'd10;
	localparam logic [7:0] Depth24        = 8'd24;
	localparam logic [7:0] Depth32        = 8'd32;
	localparam logic [7:0] CountMask      = 8'h7f;
	localparam logic [7:0] PacketRunBit   = 8'h80;
	localparam logic [7:0] AlphaOpaque    = 8'd255;
	localparam logic [7:0] RunMax         = 8'd128;

	localparam logic [2:0] BytesRgb  = 3'd3;
	localparam logic [2:0] BytesRgba = 3'd4;
	localparam logic [2:0] BytesBad  = 3'd0;

	localparam int QuotBits = 8;
	localparam int DivStep  = 4;
	localparam int DivW     = 16 + QuotBits;

endpackage

### hdl/tgadec_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA stream decoder channel
// Valid/ready channel carrying one item of a configurable type.
// ----------------------------------------------------------------------------
interface tgadec_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/tga_image_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA image stream decoder
// Parses a TGA file byte by byte and emits header, error and pixel-run items.
// ----------------------------------------------------------------------------
// byte_ch carries one file byte per item; file_start marks byte 0 of a file
// and restarts parsing. result_ch carries at most one result per byte: the
// header, an error, or a pixel run (colour, first position, count).
// A result is loaded into the output register at the edge that accepts the
// byte completing it and can be taken at the next edge. One byte per cycle
// while result_ch is not stalled. Run positions after an RLE run come from a
// divider started by the packet header byte; it is finished before the last
// pixel byte of the packet can arrive and never holds the input in practice.
// Pixel counts use one 16x16 multiply at the start of pixel data.
// When result_ch stalls, bytes that complete no result keep flowing; a byte
// that would complete one waits until the output register drains.
// Reset clears all parse state: the first bytes after reset are parsed as
// the start of a file.
// ----------------------------------------------------------------------------
module tga_image_stream_decoder_unit (
	input logic             clk,
	input logic             arst_n,
	tgadec_stream_if.sink   byte_ch,
	tgadec_stream_if.source result_ch
);

	tgadec_pkg::in_item_t  in_item;
	tgadec_pkg::out_item_t out_item_q;
	tgadec_pkg::out_item_t emit_item;
	tgadec_pkg::phase_t    phase_q, phase_d, phase_eff;

	logic [4:0]  hdr_idx_q, hdr_idx_d, hdr_idx;
	logic [7:0]  id_skip_q, id_skip_d;
	logic [7:0]  image_kind_q, image_kind_d;
	logic [2:0]  pixel_bytes_q, pixel_bytes_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [1:0]  byte_in_pixel_q, byte_in_pixel_d;
	logic [31:0] colour_q, colour_d, colour_new;
	logic [7:0]  packet_left_q, packet_left_d, packet_new;
	logic        packet_is_run_q, packet_is_run_d;
	logic [15:0] cur_row_q, cur_row_d;
	logic [15:0] cur_column_q, cur_column_d;
	logic        cmap_bad_q, cmap_bad_d;
	logic [31:0] remaining_q, remaining_d;
	logic [31:0] area;

	logic [16:0] div_rem_q, dv_rem;
	logic [7:0]  div_quo_q, dv_quo;
	logic        div_half_q, div_busy_q;
	logic [tgadec_pkg::DivW-1:0] dv_div;
	logic [2:0]  dv_sh;

	logic        in_acc, out_acc, out_valid_q;
	logic        start, emit, begin_px, use_div, run_done, last_q, div_stall, may_emit;
	logic [7:0]  b, run_n, run_cnt;

	assign in_item = byte_ch.data;
	assign b       = in_item.data_byte;
	assign start   = in_item.file_start;
	assign in_acc  = byte_ch.valid && byte_ch.ready;
	assign out_acc = out_valid_q && result_ch.ready;
	assign area    = 32'(width_q) * 32'(height_q);

	assign last_q    = ({1'b0, byte_in_pixel_q} + 3'd1) >= pixel_bytes_q;
	assign div_stall = div_busy_q && phase_q == tgadec_pkg::PH_PIXEL && packet_is_run_q
		&& last_q && image_kind_q == tgadec_pkg::TypeRle;
	assign may_emit  = (phase_q == tgadec_pkg::PH_HEADER && hdr_idx_q == tgadec_pkg::HdrLast)
		|| (phase_q == tgadec_pkg::PH_PIXEL && last_q);
	assign byte_ch.ready = !div_stall && !(out_valid_q && !result_ch.ready && may_emit);

	assign result_ch.valid = out_valid_q;
	assign result_ch.data  = out_item_q;

	assign phase_eff  = start ? tgadec_pkg::PH_HEADER : phase_q;
	assign hdr_idx    = start ? tgadec_pkg::HdrIdLen : hdr_idx_q;
	assign packet_new = (b & tgadec_pkg::CountMask) + 8'd1;

	always_comb begin
		case (byte_in_pixel_q)
			2'd0:    colour_new = {16'h0000, b, tgadec_pkg::AlphaOpaque};
			2'd1:    colour_new = {colour_q[31:24], b, colour_q[15:0]};
			2'd2:    colour_new = {b, colour_q[23:0]};
			default: colour_new = {colour_q[31:8], b};
		endcase
	end

	// next parse state and result
	always_comb begin
		phase_d         = phase_q;
		hdr_idx_d       = hdr_idx_q;
		id_skip_d       = id_skip_q;
		image_kind_d    = image_kind_q;
		pixel_bytes_d   = pixel_bytes_q;
		width_d         = width_q;
		height_d        = height_q;
		byte_in_pixel_d = byte_in_pixel_q;
		colour_d        = colour_q;
		packet_left_d   = packet_left_q;
		packet_is_run_d = packet_is_run_q;
		cur_row_d       = cur_row_q;
		cur_column_d    = cur_column_q;
		cmap_bad_d      = cmap_bad_q;
		remaining_d     = remaining_q;
		emit            = 1'b0;
		emit_item       = '0;
		begin_px        = 1'b0;
		use_div         = 1'b0;
		run_n           = 8'd1;
		run_done        = 1'b0;
		run_cnt         = 8'd1;
		if (in_acc) begin
			if (start) begin
				phase_d         = tgadec_pkg::PH_HEADER;
				hdr_idx_d       = '0;
				id_skip_d       = '0;
				image_kind_d    = '0;
				pixel_bytes_d   = tgadec_pkg::BytesRgb;
				width_d         = '0;
				height_d        = '0;
				byte_in_pixel_d = '0;
				colour_d        = '0;
				packet_left_d   = '0;
				packet_is_run_d = 1'b0;
				cur_row_d       = '0;
				cur_column_d    = '0;
				cmap_bad_d      = 1'b0;
				remaining_d     = '0;
			end
			case (phase_eff)
				tgadec_pkg::PH_HEADER: begin
					case (hdr_idx)
						tgadec_pkg::HdrIdLen:     id_skip_d = b;
						tgadec_pkg::HdrCmapType:  cmap_bad_d = (b != 8'd0);
						tgadec_pkg::HdrImageType: image_kind_d = b;
						tgadec_pkg::HdrWidthLo:   width_d = {width_q[15:8], b};
						tgadec_pkg::HdrWidthHi:   width_d = {b, width_q[7:0]};
						tgadec_pkg::HdrHeightLo:  height_d = {height_q[15:8], b};
						tgadec_pkg::HdrHeightHi:  height_d = {b, height_q[7:0]};
						tgadec_pkg::HdrDepth: begin
							if (b == tgadec_pkg::Depth24)
								pixel_bytes_d = tgadec_pkg::BytesRgb;
							else if (b == tgadec_pkg::Depth32)
								pixel_bytes_d = tgadec_pkg::BytesRgba;
							else
								pixel_bytes_d = tgadec_pkg::BytesBad;
						end
						default: ;
					endcase
					if (hdr_idx < tgadec_pkg::HdrLast) begin
						hdr_idx_d = hdr_idx + 5'd1;
					end else begin
						emit = 1'b1;
						if (image_kind_q != tgadec_pkg::TypeTrueColour
							&& image_kind_q != tgadec_pkg::TypeGrey
							&& image_kind_q != tgadec_pkg::TypeRle) begin
							emit_item.result_kind = tgadec_pkg::KindBadType;
							phase_d = tgadec_pkg::PH_DONE;
						end else if (cmap_bad_q || pixel_bytes_q == tgadec_pkg::BytesBad) begin
							emit_item.result_kind = tgadec_pkg::KindBadFormat;
							phase_d = tgadec_pkg::PH_DONE;
						end else begin
							emit_item.result_kind  = tgadec_pkg::KindHeader;
							emit_item.image_width  = width_q;
							emit_item.image_height = height_q;
							emit_item.image_done   = (width_q == 16'd0) || (height_q == 16'd0);
							if (id_skip_q != 8'd0)
								phase_d = tgadec_pkg::PH_IDSKIP;
							else
								begin_px = 1'b1;
						end
					end
				end
				tgadec_pkg::PH_IDSKIP: begin
					id_skip_d = id_skip_q - 8'd1;
					if (id_skip_q == 8'd1)
						begin_px = 1'b1;
				end
				tgadec_pkg::PH_PACKET: begin
					packet_left_d   = packet_new;
					packet_is_run_d = (b & tgadec_pkg::PacketRunBit) != 8'd0;
					byte_in_pixel_d = '0;
					phase_d         = tgadec_pkg::PH_PIXEL;
				end
				tgadec_pkg::PH_PIXEL: begin
					colour_d = colour_new;
					if (!last_q) begin
						byte_in_pixel_d = byte_in_pixel_q + 2'd1;
					end else begin
						byte_in_pixel_d = '0;
						if (image_kind_q == tgadec_pkg::TypeRle) begin
							if (packet_is_run_q) begin
								run_n         = packet_left_q;
								use_div       = 1'b1;
								packet_left_d = '0;
								phase_d       = tgadec_pkg::PH_PACKET;
							end else begin
								packet_left_d = packet_left_q - 8'd1;
								if (packet_left_q == 8'd1)
									phase_d = tgadec_pkg::PH_PACKET;
							end
						end
						run_done = remaining_q <= 32'(run_n);
						run_cnt  = run_done ? remaining_q[7:0] : run_n;
						emit                   = 1'b1;
						emit_item.result_kind  = tgadec_pkg::KindRun;
						emit_item.red          = colour_new[31:24];
						emit_item.green        = colour_new[23:16];
						emit_item.blue         = colour_new[15:8];
						emit_item.alpha        = colour_new[7:0];
						emit_item.first_row    = cur_row_q;
						emit_item.first_column = cur_column_q;
						emit_item.run_count    = run_cnt;
						emit_item.image_done   = run_done;
						if (run_done) begin
							phase_d = tgadec_pkg::PH_DONE;
						end else begin
							remaining_d = remaining_q - 32'(run_n);
							if (use_div) begin
								cur_row_d    = cur_row_q - 16'(div_quo_q);
								cur_column_d = div_rem_q[15:0];
							end else if (17'(cur_column_q) + 17'd1 == 17'(width_q)) begin
								cur_column_d = '0;
								cur_row_d    = cur_row_q - 16'd1;
							end else begin
								cur_column_d = cur_column_q + 16'd1;
							end
						end
					end
				end
				default: ;
			endcase
			if (begin_px) begin
				if (width_q == 16'd0 || height_q == 16'd0)
					phase_d = tgadec_pkg::PH_DONE;
				else if (image_kind_q == tgadec_pkg::TypeRle)
					phase_d = tgadec_pkg::PH_PACKET;
				else
					phase_d = tgadec_pkg::PH_PIXEL;
				cur_row_d       = height_q - 16'd1;
				cur_column_d    = '0;
				byte_in_pixel_d = '0;
				remaining_d     = area;
			end
		end
	end

	// run position divider: restoring, DivStep quotient bits per cycle
	always_comb begin
		dv_rem = div_rem_q;
		dv_quo = div_quo_q;
		dv_div = '0;
		dv_sh  = '0;
		for (int k = 0; k < tgadec_pkg::DivStep; k++) begin
			dv_sh  = div_half_q ? 3'(tgadec_pkg::DivStep - 1 - k)
				: 3'(tgadec_pkg::QuotBits - 1 - k);
			dv_div = tgadec_pkg::DivW'(width_q) << dv_sh;
			if (tgadec_pkg::DivW'(dv_rem) >= dv_div) begin
				dv_rem        = dv_rem - dv_div[16:0];
				dv_quo[dv_sh] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= tgadec_pkg::PH_HEADER;
			hdr_idx_q       <= '0;
			id_skip_q       <= '0;
			image_kind_q    <= '0;
			pixel_bytes_q   <= tgadec_pkg::BytesRgb;
			width_q         <= '0;
			height_q        <= '0;
			byte_in_pixel_q <= '0;
			colour_q        <= '0;
			packet_left_q   <= '0;
			packet_is_run_q <= 1'b0;
			cur_row_q       <= '0;
			cur_column_q    <= '0;
			cmap_bad_q      <= 1'b0;
			remaining_q     <= '0;
			div_busy_q      <= 1'b0;
			div_half_q      <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			phase_q         <= phase_d;
			hdr_idx_q       <= hdr_idx_d;
			id_skip_q       <= id_skip_d;
			image_kind_q    <= image_kind_d;
			pixel_bytes_q   <= pixel_bytes_d;
			width_q         <= width_d;
			height_q        <= height_d;
			byte_in_pixel_q <= byte_in_pixel_d;
			colour_q        <= colour_d;
			packet_left_q   <= packet_left_d;
			packet_is_run_q <= packet_is_run_d;
			cur_row_q       <= cur_row_d;
			cur_column_q    <= cur_column_d;
			cmap_bad_q      <= cmap_bad_d;
			remaining_q     <= remaining_d;
			if (in_acc && phase_eff == tgadec_pkg::PH_PACKET) begin
				div_busy_q <= 1'b1;
				div_half_q <= 1'b0;
			end else if (in_acc && start) begin
				div_busy_q <= 1'b0;
			end else if (div_busy_q) begin
				div_half_q <= 1'b1;
				if (div_half_q)
					div_busy_q <= 1'b0;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_acc)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && phase_eff == tgadec_pkg::PH_PACKET) begin
			div_rem_q <= 17'(cur_column_q) + 17'(packet_new);
			div_quo_q <= '0;
		end else if (div_busy_q) begin
			div_rem_q <= dv_rem;
			div_quo_q <= dv_quo;
		end
		if (emit)
			out_item_q <= emit_item;
	end

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.data.result_kind == tgadec_pkg::KindRun
		|-> result_ch.data.run_count != 8'd0 && result_ch.data.run_count <= tgadec_pkg::RunMax)
		else $error("run count out of range");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tgadec_pkg::PH_PIXEL || phase_q == tgadec_pkg::PH_PACKET
		|-> cur_column_q < width_q && remaining_q != 32'd0)
		else $error("pixel position outside image");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q && div_half_q |=> !div_busy_q || !div_half_q)
		else $error("divider overran its two cycles");

endmodule
